>>> design/multichannel_overcurrent_monitor_defines.svh
// Assertion macros shared by the over-current monitor RTL.
`ifndef MULTICHANNEL_OVERCURRENT_MONITOR_DEFINES_SVH
`define MULTICHANNEL_OVERCURRENT_MONITOR_DEFINES_SVH

`ifndef SYNTH
`define MOM_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("over-current monitor check failed");
`define MOM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("over-current monitor check failed");
`else
`define MOM_ASSERT_IMPLY(name, ante, cons)
`define MOM_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> design/mom_pkg.sv
// Types, constants and helper functions of the over-current monitor.
package mom_pkg;

	localparam int CHANNELS           = 4;
	localparam int SAMPLES_PER_WINDOW = 10;
	localparam int SAMPLES_TOTAL      = SAMPLES_PER_WINDOW * CHANNELS;
	localparam int CNT_W              = $clog2(SAMPLES_TOTAL + 1);
	localparam int CH_AW              = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int RDC_W              = $clog2(CHANNELS + 1);

	localparam int CHAN_W     = 2;
	localparam int ELAPSED_W  = 16;
	localparam int READING_W  = 10;
	localparam int INTERVAL_W = 16;
	localparam int SUM_W      = 14;
	localparam int TIME_W     = 17;
	localparam int DUR_W      = 24;
	localparam int MASK_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 16'd100;
	localparam logic [SUM_W-1:0]      THRESHOLD_RST = 14'd5000;
	localparam logic [DUR_W-1:0]      TIMEOUT_RST   = 24'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

	localparam logic KIND_TIME   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_SWEEP,
		ST_REPORT
	} mon_state_t;

	typedef struct packed {
		logic                 acc;
		logic                 rd;
		logic                 clr;
		logic [CH_AW-1:0]     addr;
		logic [READING_W-1:0] reading;
	} sum_req_t;

	typedef struct packed {
		logic             valid;
		logic [CH_AW-1:0] addr;
		logic [SUM_W-1:0] sum;
	} sum_rsp_t;

	typedef struct packed {
		logic             valid;
		logic [CH_AW-1:0] addr;
		logic             nominal;
	} dur_upd_t;

	typedef struct packed {
		logic              window_opened;
		logic              window_closed;
		logic [MASK_W-1:0] instant_over_mask;
		logic [MASK_W-1:0] fault_mask;
		logic              sample_ignored;
	} result_t;

	function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] s,
			input logic [READING_W-1:0] r);
		logic [SUM_W:0] t;
		t = {1'b0, s} + (SUM_W + 1)'(r);
		return t[SUM_W] ? '1 : t[SUM_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] a,
			input logic [ELAPSED_W-1:0] e);
		logic [TIME_W:0] t;
		t = {1'b0, a} + (TIME_W + 1)'(e);
		return t[TIME_W] ? '1 : t[TIME_W-1:0];
	endfunction

	function automatic logic [DUR_W-1:0] sat_dur(input logic [DUR_W-1:0] d,
			input logic [TIME_W-1:0] e);
		logic [DUR_W:0] t;
		t = {1'b0, d} + (DUR_W + 1)'(e);
		return t[DUR_W] ? '1 : t[DUR_W-1:0];
	endfunction

	// Channels beyond the output width are dropped, missing ones read as zero.
	function automatic logic [MASK_W-1:0] to_mask(input logic [CHANNELS-1:0] m);
		logic [CHANNELS+MASK_W-1:0] w;
		w = (CHANNELS + MASK_W)'(m);
		return w[MASK_W-1:0];
	endfunction

endpackage

>>> design/mom_item_if.sv
// Input channel of the over-current monitor: time and sample transactions.
interface mom_item_if;
	import mom_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [ELAPSED_W-1:0] elapsed_ms;
	logic [CHAN_W-1:0]    channel_index;
	logic [READING_W-1:0] adc_reading;

	modport source (output valid, kind, elapsed_ms, channel_index, adc_reading,
		input ready);
	modport sink (input valid, kind, elapsed_ms, channel_index, adc_reading,
		output ready);
endinterface

>>> design/mom_result_if.sv
// Result channel of the over-current monitor: one transaction per input item.
interface mom_result_if;
	import mom_pkg::*;

	logic              valid;
	logic              ready;
	logic              window_opened;
	logic              window_closed;
	logic [MASK_W-1:0] instant_over_mask;
	logic [MASK_W-1:0] fault_mask;
	logic              sample_ignored;

	modport source (output valid, window_opened, window_closed, instant_over_mask,
		fault_mask, sample_ignored, input ready);
	modport sink (input valid, window_opened, window_closed, instant_over_mask,
		fault_mask, sample_ignored, output ready);
endinterface

>>> design/mom_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/mom_sum_store.sv
// Per-channel sample sums: memory read-modify-write with forwarding and valid bits.
module mom_sum_store import mom_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sum_req_t req,
	output sum_rsp_t rsp
);

	logic [CHANNELS-1:0]  valid_q;
	logic                 fwd_valid_q;
	logic [CH_AW-1:0]     fwd_addr_q;
	logic [SUM_W-1:0]     fwd_sum_q;
	logic                 acc_s1;
	logic                 rd_s1;
	logic [CH_AW-1:0]     addr_s1;
	logic [READING_W-1:0] reading_s1;
	logic [SUM_W-1:0]     rdata;
	logic [SUM_W-1:0]     cur_sum;
	logic [SUM_W-1:0]     new_sum;

	mom_ram #(
		.WIDTH(SUM_W),
		.DEPTH(CHANNELS)
	) u_ram (
		.clk  (clk),
		.we   (acc_s1),
		.waddr(addr_s1),
		.wdata(new_sum),
		.raddr(req.addr),
		.rdata(rdata)
	);

	// The write of the previous transaction is not yet visible in the read data.
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == addr_s1)) begin
			cur_sum = fwd_sum_q;
		end else if (valid_q[addr_s1]) begin
			cur_sum = rdata;
		end else begin
			cur_sum = '0;
		end
		new_sum = sat_sum(cur_sum, reading_s1);
	end

	assign rsp.valid = rd_s1;
	assign rsp.addr  = addr_s1;
	assign rsp.sum   = cur_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1      <= 1'b0;
			rd_s1       <= 1'b0;
			valid_q     <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			acc_s1 <= req.acc;
			rd_s1  <= req.rd;
			// Opening a window empties every sum; it wins over a late write.
			if (req.clr) begin
				valid_q     <= '0;
				fwd_valid_q <= 1'b0;
			end else if (acc_s1) begin
				valid_q[addr_s1] <= 1'b1;
				fwd_valid_q      <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= req.addr;
		reading_s1 <= req.reading;
		if (acc_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_sum_q  <= new_sum;
		end
	end

endmodule

>>> design/mom_dur_bank.sv
// Over-current durations per channel and their timeout compare.
module mom_dur_bank import mom_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dur_upd_t            upd,
	input  logic [TIME_W-1:0]   saved_elapsed,
	input  logic [DUR_W-1:0]    timeout,
	output logic [CHANNELS-1:0] fault
);

	logic [DUR_W-1:0] dur_q [CHANNELS];

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			fault[i] = (dur_q[i] >= timeout);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				dur_q[i] <= '0;
			end
		end else if (upd.valid) begin
			if (upd.nominal) begin
				dur_q[upd.addr] <= '0;
			end else begin
				dur_q[upd.addr] <= sat_dur(dur_q[upd.addr], saved_elapsed);
			end
		end
	end

endmodule

>>> design/multichannel_overcurrent_monitor.sv
// A result is registered: it enters the output register in the cycle after its item, or the
// skid entry while the output stalls. The sample that completes a window is the exception:
// the sum memory is read back one channel per cycle, its result follows that sweep, and the
// input is held meanwhile and whenever the skid entry is full; else one item per cycle.
// Reset clears control state, durations, masks and sum valid bits at once (no clearing
// pass) and loads the registers with 100 ms, 5000 and 1000 ms.
`include "multichannel_overcurrent_monitor_defines.svh"

module multichannel_overcurrent_monitor import mom_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mom_item_if.sink              item,
	mom_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [INTERVAL_W-1:0] interval_q;
	logic [SUM_W-1:0]      threshold_q;
	logic [DUR_W-1:0]      timeout_q;

	logic [TIME_W-1:0]   time_q;
	logic [TIME_W-1:0]   saved_q;
	logic                window_open_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CHANNELS-1:0] last_over_q;
	logic [RDC_W-1:0]    rd_cnt_q;
	mon_state_t          state_q;
	mon_state_t          state_d;

	logic ready;
	logic accept;
	logic chan_ok;
	logic sample_ok;
	logic trigger;
	logic closes;
	logic sweep_issue;
	logic report_push;
	logic push;
	logic pop;

	result_t             new_res;
	result_t             out_q;
	result_t             skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;
	sum_req_t            sum_req;
	sum_rsp_t            sum_rsp;
	dur_upd_t            dur_upd;
	logic [CHANNELS-1:0] fault;

	assign accept    = item.valid && ready;
	assign chan_ok   = (32'(item.channel_index) < 32'(CHANNELS));
	assign sample_ok = window_open_q && chan_ok;
	assign trigger   = (time_q >= TIME_W'(interval_q));
	assign closes    = accept && (item.kind == KIND_SAMPLE) && sample_ok
		&& (cnt_q == CNT_W'(SAMPLES_TOTAL - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (closes) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sum_rsp.valid && (sum_rsp.addr == CH_AW'(CHANNELS - 1))) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (!skid_valid_q) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	// State outputs
	always_comb begin
		ready       = 1'b0;
		sweep_issue = 1'b0;
		report_push = 1'b0;
		unique case (state_q)
			ST_RUN:    ready       = !skid_valid_q;
			ST_SWEEP:  sweep_issue = (rd_cnt_q < RDC_W'(CHANNELS));
			ST_REPORT: report_push = !skid_valid_q;
			default:   ready       = 1'b0;
		endcase
	end

	assign item.ready = ready;

	always_comb begin
		sum_req.acc     = accept && (item.kind == KIND_SAMPLE) && sample_ok;
		sum_req.rd      = sweep_issue;
		sum_req.clr     = accept && (item.kind == KIND_TIME) && trigger;
		sum_req.addr    = sweep_issue ? rd_cnt_q[CH_AW-1:0] : CH_AW'(item.channel_index);
		sum_req.reading = item.adc_reading;
	end

	mom_sum_store u_sum_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sum_req),
		.rsp   (sum_rsp)
	);

	assign dur_upd.valid   = sum_rsp.valid;
	assign dur_upd.addr    = sum_rsp.addr;
	assign dur_upd.nominal = (sum_rsp.sum > threshold_q);

	mom_dur_bank u_dur_bank (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd          (dur_upd),
		.saved_elapsed(saved_q),
		.timeout      (timeout_q),
		.fault        (fault)
	);

	always_comb begin
		new_res                   = '0;
		new_res.instant_over_mask = to_mask(last_over_q);
		new_res.fault_mask        = to_mask(fault);
		if (report_push) begin
			new_res.window_closed = 1'b1;
		end else if (item.kind == KIND_TIME) begin
			new_res.window_opened = trigger;
		end else begin
			new_res.sample_ignored = !sample_ok;
		end
	end

	assign push = report_push || (accept && !closes);
	assign pop  = out_valid_q && result.ready;

	assign result.valid             = out_valid_q;
	assign result.window_opened     = out_q.window_opened;
	assign result.window_closed     = out_q.window_closed;
	assign result.instant_over_mask = out_q.instant_over_mask;
	assign result.fault_mask        = out_q.fault_mask;
	assign result.sample_ignored    = out_q.sample_ignored;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q    <= INTERVAL_RST;
			threshold_q   <= THRESHOLD_RST;
			timeout_q     <= TIMEOUT_RST;
			time_q        <= '0;
			saved_q       <= '0;
			window_open_q <= 1'b0;
			cnt_q         <= '0;
			last_over_q   <= '0;
			rd_cnt_q      <= '0;
			state_q       <= ST_RUN;
			out_valid_q   <= 1'b0;
			skid_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_INTERVAL:  interval_q  <= cfg_wdata[INTERVAL_W-1:0];
					REG_THRESHOLD: threshold_q <= cfg_wdata[SUM_W-1:0];
					REG_TIMEOUT:   timeout_q   <= cfg_wdata[DUR_W-1:0];
					default:       ;
				endcase
			end

			if (accept) begin
				if (item.kind == KIND_TIME) begin
					if (trigger) begin
						saved_q       <= time_q;
						time_q        <= '0;
						window_open_q <= 1'b1;
						cnt_q         <= '0;
					end else begin
						time_q <= sat_time(time_q, item.elapsed_ms);
					end
				end else if (sample_ok) begin
					if (closes) begin
						cnt_q         <= '0;
						window_open_q <= 1'b0;
						last_over_q   <= '0;
						rd_cnt_q      <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end

			if (sweep_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (dur_upd.valid && !dur_upd.nominal) begin
				last_over_q[dur_upd.addr] <= 1'b1;
			end

			// Output register with one skid entry behind it.
			if (pop || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= new_res;
			end
		end else if (push) begin
			skid_q <= new_res;
		end
	end

	`MOM_ASSERT_IMPLY(a_readback_in_sweep, sum_rsp.valid, state_q == ST_SWEEP)
	`MOM_ASSERT_NEXT(a_close_starts_sweep, closes, state_q == ST_SWEEP && !window_open_q)
	`MOM_ASSERT_IMPLY(a_skid_behind_out, skid_valid_q, out_valid_q)
	`MOM_ASSERT_IMPLY(a_no_accept_off_run, state_q != ST_RUN, !item.ready)

endmodule

>>> verif/mom_result_checker.sv
// Checker for the over-current monitor: predicts each result and compares it field by field.
module mom_result_checker import mom_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mom_item_if                   item_mon,
	mom_result_if                 result_mon,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    outstanding,
	output int                    errors
);

	localparam int TIME_CEIL = (1 << TIME_W) - 1;
	localparam int SUM_CEIL  = (1 << SUM_W) - 1;
	localparam int DUR_CEIL  = (1 << DUR_W) - 1;

	logic [INTERVAL_W-1:0] interval_ms;
	logic [SUM_W-1:0]      nominal_floor;
	logic [DUR_W-1:0]      timeout_ms;

	logic [TIME_W-1:0]   ms_since_window;
	logic [TIME_W-1:0]   banked_ms;
	logic                window_live;
	int                  samples_in_window;
	logic [SUM_W-1:0]    sums [CHANNELS];
	logic [DUR_W-1:0]    over_ms [CHANNELS];
	logic [CHANNELS-1:0] over_now;

	result_t expected_results [$];

	// Applies one transaction to the predicted state and returns the result it should produce.
	function automatic result_t advance_monitor(input logic kind,
			input logic [ELAPSED_W-1:0] elapsed, input logic [CHAN_W-1:0] chan,
			input logic [READING_W-1:0] reading);
		result_t r;
		int acc;
		r = '0;
		if (kind == KIND_TIME) begin
			if (ms_since_window >= TIME_W'(interval_ms)) begin
				// The triggering item's own time is dropped.
				banked_ms = ms_since_window;
				ms_since_window = '0;
				window_live = 1'b1;
				samples_in_window = 0;
				foreach (sums[c])
					sums[c] = '0;
				r.window_opened = 1'b1;
			end else begin
				acc = int'(ms_since_window) + int'(elapsed);
				ms_since_window = TIME_W'((acc > TIME_CEIL) ? TIME_CEIL : acc);
			end
		end else if (!window_live || int'(chan) >= CHANNELS) begin
			r.sample_ignored = 1'b1;
		end else begin
			acc = int'(sums[chan]) + int'(reading);
			sums[chan] = SUM_W'((acc > SUM_CEIL) ? SUM_CEIL : acc);
			samples_in_window++;
			if (samples_in_window >= SAMPLES_TOTAL) begin
				over_now = '0;
				for (int c = 0; c < CHANNELS; c++) begin
					if (sums[c] > nominal_floor) begin
						over_ms[c] = '0;
					end else begin
						acc = int'(over_ms[c]) + int'(banked_ms);
						over_ms[c] = DUR_W'((acc > DUR_CEIL) ? DUR_CEIL : acc);
						over_now[c] = 1'b1;
					end
				end
				window_live = 1'b0;
				samples_in_window = 0;
				r.window_closed = 1'b1;
			end
		end
		for (int c = 0; c < CHANNELS && c < MASK_W; c++) begin
			r.instant_over_mask[c] = over_now[c];
			r.fault_mask[c] = (over_ms[c] >= timeout_ms);
		end
		return r;
	endfunction

	function automatic int field_mismatch(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		int fails;
		if (!arst_n) begin
			interval_ms = INTERVAL_RST;
			nominal_floor = THRESHOLD_RST;
			timeout_ms = TIMEOUT_RST;
			ms_since_window = '0;
			banked_ms = '0;
			window_live = 1'b0;
			samples_in_window = 0;
			over_now = '0;
			foreach (sums[c]) begin
				sums[c] = '0;
				over_ms[c] = '0;
			end
			expected_results.delete();
			outstanding <= 0;
			errors <= 0;
		end else begin
			fails = 0;
			if (cfg_we) begin
				case (cfg_index)
					REG_INTERVAL:  interval_ms = cfg_wdata[INTERVAL_W-1:0];
					REG_THRESHOLD: nominal_floor = cfg_wdata[SUM_W-1:0];
					REG_TIMEOUT:   timeout_ms = cfg_wdata[DUR_W-1:0];
					default: ;
				endcase
			end
			if (item_mon.valid && item_mon.ready)
				expected_results.push_back(advance_monitor(item_mon.kind, item_mon.elapsed_ms,
					item_mon.channel_index, item_mon.adc_reading));
			if (result_mon.valid && result_mon.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transaction with none expected", $time);
					fails++;
				end else begin
					want = expected_results.pop_front();
					fails += field_mismatch("window_opened", want.window_opened,
						result_mon.window_opened);
					fails += field_mismatch("window_closed", want.window_closed,
						result_mon.window_closed);
					fails += field_mismatch("instant_over_mask", want.instant_over_mask,
						result_mon.instant_over_mask);
					fails += field_mismatch("fault_mask", want.fault_mask,
						result_mon.fault_mask);
					fails += field_mismatch("sample_ignored", want.sample_ignored,
						result_mon.sample_ignored);
				end
			end
			outstanding <= expected_results.size();
			errors <= errors + fails;
		end
	end

endmodule

>>> verif/tb.sv
// Top of the over-current monitor testbench: clock, reset, stimulus, result draining and verdict.
module tb;
	import mom_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = CHANNELS + 4;
	localparam int RANDOM_ITEMS = 1400;
	localparam int NUM_PHASES   = 7;
	localparam int LONG_STALL   = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    outstanding;
	int                    errors;
	int                    cycle_count = 0;

	int                    burst_left;
	int                    counted_items;
	logic                  long_stall_req;
	logic [INTERVAL_W-1:0] cur_interval;
	logic [SUM_W-1:0]      cur_threshold;
	int unsigned           time_banked;

	mom_item_if   item_ch ();
	mom_result_if res_ch ();

	multichannel_overcurrent_monitor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mom_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_mon    (item_ch),
		.result_mon  (res_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.outstanding (outstanding),
		.errors      (errors)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Offers one transaction, waits for it to be taken, then idles between bursts.
	task automatic send_item(input logic kind, input logic [ELAPSED_W-1:0] elapsed,
			input logic [CHAN_W-1:0] chan, input logic [READING_W-1:0] reading);
		int gap;
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.elapsed_ms <= elapsed;
		item_ch.channel_index <= chan;
		item_ch.adc_reading <= reading;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
	endtask

	// Time accounting here only decides when the next time item opens a window.
	task automatic send_time(input logic [ELAPSED_W-1:0] elapsed);
		if (time_banked >= cur_interval)
			time_banked = 0;
		else
			time_banked = time_banked + elapsed;
		counted_items++;
		send_item(KIND_TIME, elapsed, CHAN_W'($urandom), READING_W'($urandom));
	endtask

	task automatic send_sample(input logic [CHAN_W-1:0] chan, input logic [READING_W-1:0] reading,
			input bit counted);
		if (counted)
			counted_items++;
		send_item(KIND_SAMPLE, ELAPSED_W'($urandom), chan, reading);
	endtask

	task automatic open_window();
		logic [ELAPSED_W-1:0] step;
		while (time_banked < cur_interval) begin
			case ($urandom_range(0, 9))
				0: step = '0;
				1: step = ELAPSED_W'($urandom);
				default: step = ELAPSED_W'($urandom_range(cur_interval / 3, cur_interval));
			endcase
			send_time(step);
		end
		send_time(ELAPSED_W'($urandom));
	endtask

	// One measurement: open a window, then feed it samples at per-channel current levels.
	task automatic run_window();
		int level [CHANNELS];
		int order [SAMPLES_TOTAL];
		int spread, only_chan, stop_at, val, j, tmp;
		open_window();
		foreach (level[c]) begin
			case ($urandom_range(0, 3))
				0: level[c] = $urandom_range(0, 150);
				1: level[c] = $urandom_range(850, 1023);
				2: level[c] = int'(cur_threshold) / SAMPLES_PER_WINDOW;
				default: level[c] = $urandom_range(0, 1023);
			endcase
		end
		spread = $urandom_range(0, 19);
		only_chan = $urandom_range(0, CHANNELS - 1);
		for (int i = 0; i < SAMPLES_TOTAL; i++) begin
			if (spread == 0)
				order[i] = only_chan;
			else if (spread < 4)
				order[i] = $urandom_range(0, CHANNELS - 1);
			else
				order[i] = i % CHANNELS;
		end
		if (spread >= 4) begin
			for (int i = SAMPLES_TOTAL - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		// Now and then the window is cut short, so the next one reopens it.
		stop_at = ($urandom_range(0, 11) == 0) ? $urandom_range(1, SAMPLES_TOTAL - 1)
			: SAMPLES_TOTAL;
		for (int i = 0; i < stop_at; i++) begin
			if ($urandom_range(0, 15) == 0 && time_banked < cur_interval)
				send_time(ELAPSED_W'($urandom_range(0, cur_interval)));
			val = level[order[i]] + int'($urandom_range(0, 120)) - 60;
			val = (val < 0) ? 0 : (val > 1023) ? 1023 : val;
			send_sample(CHAN_W'(order[i]), READING_W'(val), 1'b1);
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2))
				send_sample(CHAN_W'($urandom), READING_W'($urandom), 1'b0);
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [INTERVAL_W-1:0] interval,
			input logic [SUM_W-1:0] threshold, input logic [DUR_W-1:0] timeout, input bit spare);
		cfg_we <= 1'b1;
		if (spare) begin
			cfg_index <= REG_SPARE;
			cfg_wdata <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_index <= REG_INTERVAL;
		cfg_wdata <= CFG_DATA_W'({$urandom, interval});
		@(posedge clk);
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= CFG_DATA_W'({$urandom, threshold});
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_wdata <= timeout;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_interval = interval;
		cur_threshold = threshold;
	endtask

	// The receiver changes its stall pattern every so often and holds off for a long
	// stretch once when asked.
	initial begin : result_drain
		int mode, left, hold;
		bit stall_taken;
		mode = 0;
		left = 0;
		hold = 0;
		stall_taken = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req && !stall_taken) begin
				stall_taken = 1'b1;
				hold = LONG_STALL;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 200);
				end
				left--;
				case (mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					2: res_ch.ready <= (left % 4 == 0);
					default: res_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int goal;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_INTERVAL;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.kind <= KIND_TIME;
		item_ch.elapsed_ms <= '0;
		item_ch.channel_index <= '0;
		item_ch.adc_reading <= '0;
		burst_left = 0;
		counted_items = 0;
		long_stall_req = 1'b0;
		cur_interval = INTERVAL_RST;
		cur_threshold = THRESHOLD_RST;
		time_banked = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Samples before any window are ignored.
		send_sample(2'd3, 10'h3FF, 1'b1);
		send_sample(2'd0, 10'h000, 1'b1);
		send_time(16'h0000);
		send_time(16'hFFFF);
		// This one reaches the interval and opens a window; its own time is dropped.
		send_time(16'h0001);
		send_sample(2'd0, 10'h3FF, 1'b1);
		send_sample(2'd1, 10'h000, 1'b1);
		send_sample(2'd2, 10'h2AA, 1'b1);
		send_sample(2'd3, 10'h155, 1'b1);
		send_time(16'h5555);
		// Reopening while a window is open discards the partial sums.
		send_time(16'hAAAA);
		send_time(16'h0000);
		send_sample(2'd1, 10'h3FF, 1'b1);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0)
				settle();
			case (phase)
				1: program_regs(16'd1, 14'd0, 24'd0, 1'b1);
				2: program_regs(16'hFFFF, 14'h3FFF, 24'hFFFFFF, 1'b0);
				3: program_regs(16'd50, 14'd4000, 24'd200, 1'b0);
				4: program_regs(16'd0, 14'd10230, DUR_W'($urandom_range(0, 300)), 1'b0);
				5: program_regs(INTERVAL_W'($urandom_range(1, 300)),
					SUM_W'($urandom_range(3000, 7000)), DUR_W'($urandom_range(0, 1500)), 1'b1);
				6: program_regs(INTERVAL_W'($urandom_range(1, 2000)),
					SUM_W'($urandom_range(0, 16383)), DUR_W'($urandom_range(0, 5000)), 1'b0);
				default: ;
			endcase
			if (phase == 3) begin
				// Keep offering items while the receiver holds off, so the input backs up.
				long_stall_req = 1'b1;
				burst_left = 80;
			end
			goal = counted_items + RANDOM_ITEMS / NUM_PHASES;
			while (counted_items < goal)
				run_window();
		end

		settle();
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
